// ===== hw/rtl/base64_codec_defines.svh =====
// Assertion macros for the base64 codec RTL.
// No dependencies; included by files that carry assertions.
`ifndef BASE64_CODEC_DEFINES_SVH
`define BASE64_CODEC_DEFINES_SVH

`ifndef ASSERT_OFF

// ante true at an edge -> cons true at the same edge
`define B64_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("base64_codec: assertion failed");

// ante true at an edge -> cons true at the next edge
`define B64_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("base64_codec: assertion failed");

`else

`define B64_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define B64_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/b64_pkg.sv =====
// Shared types, constants and alphabet functions for the base64 codec.
// No dependencies; used by b64_step and base64_codec.
`timescale 1ns / 1ps

package b64_pkg;

    localparam int COUNT_WIDTH = 20;
    localparam int JOB_DEPTH   = 5;   // most requests one input can produce
    localparam int JOB_CNT_W   = 3;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

    typedef struct packed {
        logic [1:0]             group_pos;
        logic [5:0]             carry_bits;
        logic                   stopped;
        logic                   bad_char;
        logic [COUNT_WIDTH-1:0] emitted_count;
    } t_state;

    typedef struct packed {
        logic                   kind;
        logic [7:0]             out_byte;
        logic [1:0]             status;
        logic [COUNT_WIDTH-1:0] total;
        logic                   last_out;
    } t_res;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sext;

    // sextet -> alphabet character
    function automatic logic [7:0] char_of(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = 8'h41 + {2'b00, s};
        end else if (s < 6'd52) begin
            c = 8'h61 + {2'b00, s} - 8'd26;
        end else if (s < 6'd62) begin
            c = 8'h30 + {2'b00, s} - 8'd52;
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // character -> sextet; '=' maps to 63, unknown characters to 0 with ok low
    function automatic t_sext sextet_of(input logic [7:0] c);
        t_sext r;
        r.ok  = 1'b1;
        r.val = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            r.val = 6'd62;
        end else if (c == 8'h2F || c == PAD_CHAR) begin
            r.val = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/b64_step.sv =====
// Combinational step: one input element against the stream state gives the
// next state and the requests it produces. Depends on b64_pkg.
`timescale 1ns / 1ps

module b64_step (
    input  logic              i_mode,
    input  b64_pkg::t_state   i_state,
    input  logic [7:0]        i_in_byte,
    input  logic              i_last_in,
    output b64_pkg::t_state   o_state,
    output b64_pkg::t_res     o_res [b64_pkg::JOB_DEPTH],
    output logic [b64_pkg::JOB_CNT_W-1:0] o_cnt
);

    logic [7:0]                       data [b64_pkg::JOB_DEPTH];
    logic [b64_pkg::JOB_CNT_W-1:0]    nd;
    b64_pkg::t_state                  n_state;
    b64_pkg::t_sext                   sx;
    logic [1:0]                       pos;
    logic [1:0]                       epos;
    logic                             stop_n;
    logic                             bad_n;
    logic [b64_pkg::COUNT_WIDTH:0]    sum;
    logic [b64_pkg::COUNT_WIDTH-1:0]  cnt_sat;
    logic [1:0]                       status;

    always_comb begin
        n_state = i_state;
        for (int i = 0; i < b64_pkg::JOB_DEPTH; i++) begin
            data[i] = 8'h00;
        end
        nd     = '0;
        sx     = b64_pkg::sextet_of(i_in_byte);
        pos    = i_state.group_pos;
        epos   = (pos == 2'd3) ? 2'd0 : pos;
        stop_n = i_state.stopped;
        bad_n  = i_state.bad_char;

        if (i_mode == b64_pkg::MODE_ENCODE) begin
            case (epos)
                2'd0: begin
                    data[0]              = b64_pkg::char_of(i_in_byte[7:2]);
                    nd                   = 3'd1;
                    n_state.carry_bits   = {i_in_byte[1:0], 4'b0000};
                    n_state.group_pos    = 2'd1;
                end
                2'd1: begin
                    data[0]              = b64_pkg::char_of(i_state.carry_bits |
                                                            {2'b00, i_in_byte[7:4]});
                    nd                   = 3'd1;
                    n_state.carry_bits   = {i_in_byte[3:0], 2'b00};
                    n_state.group_pos    = 2'd2;
                end
                default: begin
                    data[0]              = b64_pkg::char_of(i_state.carry_bits |
                                                            {4'b0000, i_in_byte[7:6]});
                    data[1]              = b64_pkg::char_of(i_in_byte[5:0]);
                    nd                   = 3'd2;
                    n_state.carry_bits   = 6'd0;
                    n_state.group_pos    = 2'd0;
                end
            endcase
            if (i_last_in) begin
                // close the group with padding
                if (n_state.group_pos == 2'd1) begin
                    data[1] = b64_pkg::char_of(n_state.carry_bits);
                    data[2] = b64_pkg::PAD_CHAR;
                    data[3] = b64_pkg::PAD_CHAR;
                    nd      = 3'd4;
                end else if (n_state.group_pos == 2'd2) begin
                    data[1] = b64_pkg::char_of(n_state.carry_bits);
                    data[2] = b64_pkg::PAD_CHAR;
                    nd      = 3'd3;
                end
                n_state.group_pos = 2'd0;
            end
        end else begin
            bad_n  = i_state.bad_char | ~sx.ok;
            stop_n = i_state.stopped |
                     ((pos == 2'd2 || pos == 2'd3) && i_in_byte == b64_pkg::PAD_CHAR);
            case (pos)
                2'd0: begin
                    n_state.carry_bits = sx.val;
                end
                2'd1: begin
                    data[0]            = {i_state.carry_bits, sx.val[5:4]};
                    nd                 = stop_n ? 3'd0 : 3'd1;
                    n_state.carry_bits = {2'b00, sx.val[3:0]};
                end
                2'd2: begin
                    data[0]            = {i_state.carry_bits[3:0], sx.val[5:2]};
                    nd                 = stop_n ? 3'd0 : 3'd1;
                    n_state.carry_bits = {4'b0000, sx.val[1:0]};
                end
                default: begin
                    data[0]            = {i_state.carry_bits[1:0], sx.val};
                    nd                 = stop_n ? 3'd0 : 3'd1;
                    n_state.carry_bits = 6'd0;
                end
            endcase
            n_state.group_pos = pos + 2'd1;
        end
        n_state.stopped  = stop_n;
        n_state.bad_char = bad_n;

        // saturating data count
        sum = {1'b0, i_state.emitted_count} +
              {{(b64_pkg::COUNT_WIDTH - 2){1'b0}}, nd};
        cnt_sat = sum[b64_pkg::COUNT_WIDTH] ? '1 : sum[b64_pkg::COUNT_WIDTH-1:0];
        n_state.emitted_count = cnt_sat;

        if (i_mode == b64_pkg::MODE_DECODE && n_state.group_pos != 2'd0) begin
            status = b64_pkg::STATUS_BAD_LEN;
        end else if (bad_n) begin
            status = b64_pkg::STATUS_BAD_CHAR;
        end else begin
            status = b64_pkg::STATUS_OK;
        end

        for (int i = 0; i < b64_pkg::JOB_DEPTH; i++) begin
            if (b64_pkg::JOB_CNT_W'(i) < nd) begin
                o_res[i].kind     = b64_pkg::KIND_DATA;
                o_res[i].out_byte = data[i];
                o_res[i].status   = b64_pkg::STATUS_OK;
                o_res[i].total    = '0;
                o_res[i].last_out = 1'b0;
            end else begin
                o_res[i].kind     = b64_pkg::KIND_STATUS;
                o_res[i].out_byte = 8'h00;
                o_res[i].status   = status;
                o_res[i].total    = cnt_sat;
                o_res[i].last_out = 1'b1;
            end
        end

        o_cnt = nd + {2'b00, i_last_in};

        if (i_last_in) begin
            n_state = '0;
        end
        o_state = n_state;
    end

endmodule

// ===== hw/rtl/base64_codec.sv =====
// Top level of the streaming Base64 codec: mode register, stream state,
// request buffer and output register. Depends on b64_pkg, b64_step and
// base64_codec_defines.svh.
//
//  channel   | valid       | ready        | payload
//  ----------+-------------+--------------+---------------------------------------
//  cfg write | i_cfg_valid | o_cfg_ready  | i_cfg_mode
//  input     | i_valid     | o_ready      | i_in_byte, i_last_in
//  output    | o_valid     | i_ready      | o_kind, o_out_byte, o_status, o_total,
//            |             |              | o_last_out
//
// An accepted element is worked in the cycle of acceptance; its 0 to 5
// requests land in a small buffer and leave through the output register one
// per cycle while the output is not stalled: one or two requests per byte
// while encoding mid-stream (two on the byte that closes a group), at most
// one per character while decoding.
// Reset (synchronous, active low) clears mode to encode and the stream state.
// A stalled output holds the register; the buffer fills and o_ready drops
// until the buffer is down to its last request and that one moves.
`timescale 1ns / 1ps
`include "base64_codec_defines.svh"

module base64_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_mode,
    // input stream
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_in,
    // output stream
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic [b64_pkg::COUNT_WIDTH-1:0] o_total,
    output logic        o_last_out
);

    logic                           r_mode;
    b64_pkg::t_state                r_state;
    b64_pkg::t_res                  r_job [b64_pkg::JOB_DEPTH];
    logic [b64_pkg::JOB_CNT_W-1:0]  r_cnt;
    b64_pkg::t_res                  r_out;
    logic                           r_out_valid;

    b64_pkg::t_state                n_state;
    b64_pkg::t_res                  w_res [b64_pkg::JOB_DEPTH];
    logic [b64_pkg::JOB_CNT_W-1:0]  w_cnt;
    logic                           w_load;
    logic                           w_accept;

    b64_step u_step (
        .i_mode    (r_mode),
        .i_state   (r_state),
        .i_in_byte (i_in_byte),
        .i_last_in (i_last_in),
        .o_state   (n_state),
        .o_res     (w_res),
        .o_cnt     (w_cnt)
    );

    // head of the buffer moves when the output register is free or draining
    assign w_load   = (r_cnt != '0) && (!r_out_valid || i_ready);
    // take a new element once the buffer empties in this cycle
    assign o_ready  = (r_cnt == '0) || (r_cnt == 3'd1 && w_load);
    assign w_accept = i_valid && o_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= b64_pkg::MODE_ENCODE;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // request buffer: loaded whole, drained from the head by shifting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_accept) begin
            r_cnt <= w_cnt;
        end else if (w_load) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job <= w_res;
        end else if (w_load) begin
            for (int i = 0; i < b64_pkg::JOB_DEPTH - 1; i++) begin
                r_job[i] <= r_job[i+1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= r_job[0];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_out.kind;
    assign o_out_byte = r_out.out_byte;
    assign o_status   = r_out.status;
    assign o_total    = r_out.total;
    assign o_last_out = r_out.last_out;

    // buffer never holds more than one element's worth of requests
    `B64_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 3'd5)
    // a closing element always leaves at least its status request behind
    `B64_ASSERT_NXT(a_last_queued, i_clk, i_rst_n, w_accept && i_last_in, r_cnt != '0)
    // the stream state starts over after a closing element
    `B64_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, w_accept && i_last_in,
                    r_state.group_pos == 2'd0 && r_state.emitted_count == '0)
    // status requests, and only those, close the stream
    `B64_ASSERT_IMP(a_kind_last, i_clk, i_rst_n, o_valid, o_kind == o_last_out)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for base64_codec: directed and random streams in both modes,
// a running prediction of every request, and field-by-field checking at the output.
// Depends on b64_pkg and the base64_codec RTL.

module tb;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 16;         // request buffer plus output register
    localparam int RANDOM_ITEMS  = 60;
    localparam int HOLD_CYCLES   = 60;
    localparam logic [b64_pkg::COUNT_WIDTH-1:0] COUNT_TOP = '1;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic                            i_cfg_mode  = 1'b0;
    logic                            i_valid     = 1'b0;
    logic                            o_ready;
    logic [7:0]                      i_in_byte   = 8'h00;
    logic                            i_last_in   = 1'b0;
    logic                            o_valid;
    logic                            i_ready     = 1'b0;
    logic                            o_kind;
    logic [7:0]                      o_out_byte;
    logic [1:0]                      o_status;
    logic [b64_pkg::COUNT_WIDTH-1:0] o_total;
    logic                            o_last_out;

    base64_codec i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_mode  (i_cfg_mode),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_last_in   (i_last_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_total     (o_total),
        .o_last_out  (o_last_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predicted codec state; mirrors what the block should hold.
    // ------------------------------------------------------------------
    string                           b64_chars =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    b64_pkg::t_res                   awaited_res[$];     // requests still to come, oldest first
    logic                            pm_mode;
    logic [1:0]                      pm_pos;
    logic [5:0]                      pm_carry;
    logic                            pm_stop;
    logic                            pm_bad;
    logic [b64_pkg::COUNT_WIDTH-1:0] pm_count;

    int errors   = 0;
    int cycles   = 0;
    bit src_idle = 1'b0;   // random gaps before each input
    bit snk_idle = 1'b0;   // random gaps before each output accept
    int hold_off = 0;      // one-shot long output stall, picked up by the sink

    logic [7:0] stream_buf[$];

    task automatic clear_stream_state();
        pm_pos   = 2'd0;
        pm_carry = 6'd0;
        pm_stop  = 1'b0;
        pm_bad   = 1'b0;
        pm_count = '0;
    endtask

    task automatic expect_data(input logic [7:0] b);
        b64_pkg::t_res r;
        r          = '0;
        r.kind     = b64_pkg::KIND_DATA;
        r.out_byte = b;
        r.status   = b64_pkg::STATUS_OK;
        awaited_res.push_back(r);
        if (pm_count != COUNT_TOP) pm_count++;
    endtask

    task automatic expect_char(input logic [5:0] s);
        expect_data(8'(b64_chars[s]));
    endtask

    // Alphabet lookup; '=' reads as 63, anything else outside the set as 0 with valid low.
    function automatic logic [5:0] sextet_value(input logic [7:0] c, output logic valid);
        valid = 1'b1;
        if (c >= "A" && c <= "Z") return 6'(c - "A");
        if (c >= "a" && c <= "z") return 6'(c - "a" + 8'd26);
        if (c >= "0" && c <= "9") return 6'(c - "0" + 8'd52);
        if (c == "+") return 6'd62;
        if (c == "/" || c == b64_pkg::PAD_CHAR) return 6'd63;
        valid = 1'b0;
        return 6'd0;
    endfunction

    // Queues the requests one accepted element should produce.
    task automatic predict_codec(input logic [7:0] b, input logic last);
        logic [1:0]    pos;
        logic [5:0]    s;
        logic          ok;
        b64_pkg::t_res r;
        pos = pm_pos;
        if (pm_mode == b64_pkg::MODE_ENCODE) begin
            // a group left at three by decode restarts
            if (pos == 2'd3) pos = 2'd0;
            case (pos)
                2'd0: begin
                    expect_char(b[7:2]);
                    pm_carry = {b[1:0], 4'b0000};
                    pm_pos   = 2'd1;
                end
                2'd1: begin
                    expect_char(pm_carry | {2'b00, b[7:4]});
                    pm_carry = {b[3:0], 2'b00};
                    pm_pos   = 2'd2;
                end
                default: begin
                    expect_char(pm_carry | {4'b0000, b[7:6]});
                    expect_char(b[5:0]);
                    pm_carry = 6'd0;
                    pm_pos   = 2'd0;
                end
            endcase
            if (last) begin
                if (pm_pos == 2'd1) begin
                    expect_char(pm_carry);
                    expect_data(b64_pkg::PAD_CHAR);
                    expect_data(b64_pkg::PAD_CHAR);
                end else if (pm_pos == 2'd2) begin
                    expect_char(pm_carry);
                    expect_data(b64_pkg::PAD_CHAR);
                end
                pm_pos = 2'd0;
            end
        end else begin
            s = sextet_value(b, ok);
            if (!ok) pm_bad = 1'b1;
            // pad in third or fourth slot silences the rest of the stream
            if (pos[1] && b == b64_pkg::PAD_CHAR) pm_stop = 1'b1;
            case (pos)
                2'd0: pm_carry = s;
                2'd1: begin
                    if (!pm_stop) expect_data({pm_carry, s[5:4]});
                    pm_carry = {2'b00, s[3:0]};
                end
                2'd2: begin
                    if (!pm_stop) expect_data({pm_carry[3:0], s[5:2]});
                    pm_carry = {4'b0000, s[1:0]};
                end
                default: begin
                    if (!pm_stop) expect_data({pm_carry[1:0], s});
                    pm_carry = 6'd0;
                end
            endcase
            pm_pos = pos + 2'd1;
        end
        if (last) begin
            r          = '0;
            r.kind     = b64_pkg::KIND_STATUS;
            // bad length outranks bad character
            if (pm_mode == b64_pkg::MODE_DECODE && pm_pos != 2'd0)
                r.status = b64_pkg::STATUS_BAD_LEN;
            else if (pm_bad) r.status = b64_pkg::STATUS_BAD_CHAR;
            else r.status = b64_pkg::STATUS_OK;
            r.total    = pm_count;
            r.last_out = 1'b1;
            awaited_res.push_back(r);
            clear_stream_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers: everything changes on the falling edge.
    // ------------------------------------------------------------------
    task automatic send_element(input logic [7:0] b, input logic last);
        int gap;
        gap = src_idle ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_last_in <= last;
        do @(posedge i_clk); while (!o_ready);
        predict_codec(b, last);
    endtask

    task automatic send_text(input string s, input logic closes);
        for (int i = 0; i < s.len(); i++) begin
            send_element(s[i], closes && (i == s.len() - 1));
        end
    endtask

    task automatic send_buf();
        for (int i = 0; i < stream_buf.size(); i++) begin
            send_element(stream_buf[i], i == stream_buf.size() - 1);
        end
        stream_buf.delete();
    endtask

    task automatic write_mode(input logic m);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_mode  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        pm_mode = m;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid, let every awaited request arrive, then let the pipe settle
    // (a decode char in slot one produces nothing and may still be in flight).
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (awaited_res.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Output side: random ready gaps, plus a long stall when a test asks for one.
    initial begin : result_sink
        int gap;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_ready <= 1'b0;
                repeat (hold_off) @(negedge i_clk);
                hold_off = 0;
            end
            gap = snk_idle ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // ------------------------------------------------------------------
    // Checker: every accepted request against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got) begin
            errors++;
            $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        b64_pkg::t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_res.size() == 0) begin
                errors++;
                $display("%0t unawaited request: expected none, got kind %0h byte %0h",
                         $time, o_kind, o_out_byte);
            end else begin
                want = awaited_res.pop_front();
                check_field("kind",     want.kind,     o_kind);
                check_field("out_byte", want.out_byte, o_out_byte);
                check_field("status",   want.status,   o_status);
                check_field("total",    want.total,    o_total);
                check_field("last_out", want.last_out, o_last_out);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[base64_codec] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Encode straight out of reset: full group, two pads, one pad; byte extremes.
    task automatic test_encode_groups();
        send_element(8'hFF, 1'b0);
        send_element(8'h00, 1'b0);
        send_element(8'hFF, 1'b1);
        send_element(8'h00, 1'b1);
        send_element(8'hFF, 1'b0);
        send_element(8'h80, 1'b1);
        wait_idle();
    endtask

    // Decode rules: pad early counts as 63, pad late stops output but later
    // chars are still checked, both errors at once, pad in the fourth slot.
    task automatic test_decode_rules();
        write_mode(b64_pkg::MODE_DECODE);
        send_text("==//", 1'b1);
        send_text("QQ=", 1'b0);
        send_element(8'h80, 1'b1);
        send_text("A!B", 1'b1);
        send_text("QUJ=", 1'b1);
        wait_idle();
    endtask

    // Mode flips mid-stream: state carries over; encode restarts a group left at three.
    task automatic test_mode_switch();
        send_text("AB", 1'b0);
        wait_idle();
        write_mode(b64_pkg::MODE_ENCODE);
        send_element(8'h5A, 1'b1);
        wait_idle();
        write_mode(b64_pkg::MODE_DECODE);
        send_text("A*C", 1'b0);
        wait_idle();
        write_mode(b64_pkg::MODE_ENCODE);
        send_element(8'hC3, 1'b1);
        wait_idle();
    endtask

    // Long output stall while encode keeps pushing: buffer fills, o_ready drops.
    task automatic test_output_stall();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        hold_off = HOLD_CYCLES;
        for (int i = 0; i < 24; i++) begin
            send_element(8'($urandom_range(0, 255)), i == 23);
        end
        wait_idle();
    endtask

    // Random streams, mostly well-formed in decode, with noise and broken lengths.
    task automatic test_random_streams();
        int   sent;
        int   groups;
        int   len;
        logic m;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            m = 1'($urandom_range(0, 1));
            if (m != pm_mode) write_mode(m);
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            if (m == b64_pkg::MODE_ENCODE) begin
                len = $urandom_range(1, 10);
                repeat (len) stream_buf.push_back(8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 3) != 0) begin
                groups = $urandom_range(1, 3);
                repeat (4 * groups) stream_buf.push_back(8'(b64_chars[$urandom_range(0, 63)]));
                case ($urandom_range(0, 2))
                    1: stream_buf[stream_buf.size() - 1] = b64_pkg::PAD_CHAR;
                    2: begin
                        stream_buf[stream_buf.size() - 1] = b64_pkg::PAD_CHAR;
                        stream_buf[stream_buf.size() - 2] = b64_pkg::PAD_CHAR;
                    end
                    default: ;
                endcase
                // now and then a stray byte anywhere in the stream
                if ($urandom_range(0, 7) == 0)
                    stream_buf[$urandom_range(0, stream_buf.size() - 1)] =
                        8'($urandom_range(0, 255));
            end else begin
                len = $urandom_range(1, 9);
                repeat (len) begin
                    case ($urandom_range(0, 2))
                        0: stream_buf.push_back(8'($urandom_range(0, 255)));
                        1: stream_buf.push_back(b64_pkg::PAD_CHAR);
                        default: stream_buf.push_back(8'(b64_chars[$urandom_range(0, 63)]));
                    endcase
                end
            end
            sent += stream_buf.size();
            send_buf();
            wait_idle();
        end
    endtask

    initial begin
        pm_mode = b64_pkg::MODE_ENCODE;
        clear_stream_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_encode_groups();
        test_decode_rules();
        test_mode_switch();
        test_output_stall();
        test_random_streams();

        wait_idle();
        if (errors == 0) begin
            $display("[base64_codec] OK");
        end else begin
            $display("[base64_codec] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/b64_pkg.sv
hw/rtl/b64_step.sv
hw/rtl/base64_codec.sv
dv/tb.sv
